[rtl/rbam_pkg.sv]
// ----------------------------------------------------------------------------
// Radial brush alpha mask package
// Shared widths, constants, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package rbam_pkg;

  localparam int unsigned CoordW    = 9;
  localparam int unsigned RegW      = 9;
  localparam int unsigned AlphaW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DeltaW    = 10;
  localparam int unsigned SqW       = 17;
  localparam int unsigned D2W       = 18;
  localparam int unsigned FracW     = 16;
  localparam int unsigned RadW      = D2W + FracW;
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned RemW      = RootW + 4;
  localparam int unsigned LenW      = 17;
  localparam int unsigned NumW      = LenW + AlphaW;
  localparam int unsigned QueueDepth = 2;

  localparam logic [RegW-1:0]   MaxRadius = RegW'(256);
  localparam logic [RegW-1:0]   HardOne   = RegW'(256);
  localparam logic [AlphaW-1:0] AlphaFull = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBrushRadius  = 2'd0,
    CfgCanvasRadius = 2'd1,
    CfgHardness     = 2'd2,
    CfgUnused       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                     kill;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic [RegW-1:0]          rad;
    logic [RegW-1:0]          hard;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

endpackage

[rtl/rbam_front.sv]
// ----------------------------------------------------------------------------
// Radial brush alpha mask front end
// Holds the configuration, accepts pixels and classifies them against the
// canvas and the brush square.
// ----------------------------------------------------------------------------
module rbam_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [rbam_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rbam_pkg::RegW-1:0]         cfg_data_i,
  input  logic                              start_i,
  input  logic                              full_i,
  input  logic [rbam_pkg::CoordW-1:0]       pixel_x_i,
  input  logic [rbam_pkg::CoordW-1:0]       pixel_y_i,
  output rbam_pkg::push_t                   push_o
);

  logic [rbam_pkg::RegW-1:0] brush_q, canvas_q, hard_q;
  logic [rbam_pkg::RegW-1:0] rad, can, hard;
  logic signed [rbam_pkg::RegW+1:0] lx, ly, dx, dy;
  logic [rbam_pkg::RegW+1:0] can2, rad2;
  logic kill;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_q  <= '0;
      canvas_q <= '0;
      hard_q   <= '0;
    end else if (cfg_valid_i) begin
      case (rbam_pkg::cfg_idx_e'(cfg_index_i))
        rbam_pkg::CfgBrushRadius:  brush_q  <= cfg_data_i;
        rbam_pkg::CfgCanvasRadius: canvas_q <= cfg_data_i;
        rbam_pkg::CfgHardness:     hard_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rad  = (brush_q > rbam_pkg::MaxRadius) ? rbam_pkg::MaxRadius : brush_q;
    can  = (canvas_q > rbam_pkg::MaxRadius) ? rbam_pkg::MaxRadius : canvas_q;
    hard = (hard_q > rbam_pkg::HardOne) ? rbam_pkg::HardOne : hard_q;
    can2 = {1'b0, can, 1'b0};
    rad2 = {1'b0, rad, 1'b0};
    lx = $signed({2'b00, pixel_x_i}) + $signed({2'b00, rad}) - $signed({2'b00, can});
    ly = $signed({2'b00, pixel_y_i}) + $signed({2'b00, rad}) - $signed({2'b00, can});
    dx = $signed({2'b00, pixel_x_i}) - $signed({2'b00, can});
    dy = $signed({2'b00, pixel_y_i}) - $signed({2'b00, can});
    kill = (rad == '0) || (can == '0)
        || ({2'b00, pixel_x_i} >= can2) || ({2'b00, pixel_y_i} >= can2)
        || lx[rbam_pkg::RegW+1] || ly[rbam_pkg::RegW+1]
        || (lx >= $signed(rad2)) || (ly >= $signed(rad2));
    push_o.push      = start_i && !full_i;
    push_o.item.kill = kill;
    push_o.item.dx   = dx[rbam_pkg::DeltaW-1:0];
    push_o.item.dy   = dy[rbam_pkg::DeltaW-1:0];
    push_o.item.rad  = rad;
    push_o.item.hard = hard;
  end

endmodule

[rtl/rbam_queue.sv]
// ----------------------------------------------------------------------------
// Radial brush alpha mask queue
// Short FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module rbam_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rbam_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output rbam_pkg::item_t item_o
);

  rbam_pkg::item_t mem_q [rbam_pkg::QueueDepth];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic do_pop;

  assign full_o  = (cnt_q == 2'(rbam_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push_i.push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/rbam_back.sv]
// ----------------------------------------------------------------------------
// Radial brush alpha mask back end
// Squares, bit-serial pipelined square root, falloff and pipelined divide.
// ----------------------------------------------------------------------------
module rbam_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rbam_pkg::item_t               item_i,
  output logic                          alpha_valid_o,
  output logic [rbam_pkg::AlphaW-1:0]   alpha_o
);

  localparam int unsigned RootW = rbam_pkg::RootW;
  localparam int unsigned RemW  = rbam_pkg::RemW;
  localparam int unsigned RadW  = rbam_pkg::RadW;
  localparam int unsigned LenW  = rbam_pkg::LenW;
  localparam int unsigned NumW  = rbam_pkg::NumW;
  localparam int unsigned AW    = rbam_pkg::AlphaW;

  // squares
  logic                       s0_vld_q, s0_kill_q;
  logic [rbam_pkg::SqW-1:0]   s0_sqx_q, s0_sqy_q;
  logic [LenW-1:0]            s0_core_q, s0_rim_q;
  logic signed [2*rbam_pkg::DeltaW-1:0] sqx, sqy;

  assign sqx = item_i.dx * item_i.dx;
  assign sqy = item_i.dy * item_i.dy;

  always_ff @(posedge clk_i) begin
    s0_kill_q <= item_i.kill;
    s0_sqx_q  <= sqx[rbam_pkg::SqW-1:0];
    s0_sqy_q  <= sqy[rbam_pkg::SqW-1:0];
    s0_core_q <= LenW'(item_i.rad * item_i.hard);
    s0_rim_q  <= {item_i.rad[LenW-9:0], 8'b0};
  end

  // square root pipeline, one root bit per stage
  logic            sk_q   [RootW+1];
  logic [LenW-1:0] sc_q   [RootW+1];
  logic [LenW-1:0] sr_q   [RootW+1];
  logic [RadW-1:0] sv2_q  [RootW+1];
  logic [RootW-1:0] rt_q  [RootW+1];
  logic [RemW-1:0] rm_q   [RootW+1];

  always_ff @(posedge clk_i) begin
    sk_q[0]  <= s0_kill_q;
    sc_q[0]  <= s0_core_q;
    sr_q[0]  <= s0_rim_q;
    sv2_q[0] <= {(rbam_pkg::D2W)'(s0_sqx_q) + (rbam_pkg::D2W)'(s0_sqy_q),
                 (rbam_pkg::FracW)'(0)};
    rt_q[0]  <= '0;
    rm_q[0]  <= '0;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [RemW-1:0] rem2, trial;
    logic            ge;
    assign rem2  = {rm_q[k][RemW-3:0], sv2_q[k][RadW-1:RadW-2]};
    assign trial = {2'b00, rt_q[k], 2'b01};
    assign ge    = (rem2 >= trial);
    always_ff @(posedge clk_i) begin
      sk_q[k+1]  <= sk_q[k];
      sc_q[k+1]  <= sc_q[k];
      sr_q[k+1]  <= sr_q[k];
      sv2_q[k+1] <= {sv2_q[k][RadW-3:0], 2'b00};
      rt_q[k+1]  <= {rt_q[k][RootW-2:0], ge};
      rm_q[k+1]  <= ge ? (rem2 - trial) : rem2;
    end
  end

  // falloff numerator and denominator, then restoring divide
  logic [RootW-1:0] root;
  logic [LenW-1:0]  diff;
  logic            dz_q  [AW+1];
  logic            df_q  [AW+1];
  logic [NumW-1:0] dn_q  [AW+1];
  logic [LenW-1:0] dd_q  [AW+1];
  logic [AW-1:0]   dq_q  [AW+1];

  assign root = rt_q[RootW];
  assign diff = sr_q[RootW] - root[LenW-1:0];

  always_ff @(posedge clk_i) begin
    dz_q[0] <= sk_q[RootW] || (RootW'(sr_q[RootW]) < root);
    df_q[0] <= (root <= RootW'(sc_q[RootW]));
    dn_q[0] <= {diff, 8'b0} - NumW'(diff);
    dd_q[0] <= sr_q[RootW] - sc_q[RootW];
    dq_q[0] <= '0;
  end

  for (genvar j = 0; j < AW; j++) begin : g_div
    logic [NumW-1:0] dsh;
    logic            ge;
    assign dsh = NumW'(dd_q[j]) << (AW-1-j);
    assign ge  = (dn_q[j] >= dsh);
    always_ff @(posedge clk_i) begin
      dz_q[j+1] <= dz_q[j];
      df_q[j+1] <= df_q[j];
      dn_q[j+1] <= ge ? (dn_q[j] - dsh) : dn_q[j];
      dd_q[j+1] <= dd_q[j];
      dq_q[j+1] <= {dq_q[j][AW-2:0], ge};
    end
  end

  logic [AW+RootW+2:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      s0_vld_q <= valid_i;
      vld_q    <= {vld_q[AW+RootW+1:0], s0_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_o <= dz_q[AW] ? '0 : (df_q[AW] ? rbam_pkg::AlphaFull : dq_q[AW]);
  end

  assign alpha_valid_o = vld_q[AW+RootW+2];

endmodule

[rtl/radial_brush_alpha_mask_core.sv]
// ----------------------------------------------------------------------------
// Radial brush alpha mask core
// Returns the opacity of a round brush for one canvas pixel per transaction.
// ----------------------------------------------------------------------------
// Channels: a pixel (pixel_x_i, pixel_y_i) is taken at each clock edge with
// start_i high and busy_o low. Each result shows on alpha_o for one cycle with
// alpha_valid_o high, in the order the pixels were taken; the receiver cannot
// stall, so the back end never holds and busy_o stays low in normal use.
// Configuration: cfg_index_i selects brush radius (0), canvas radius (1) or
// hardness (2); a write lands when cfg_valid_i and cfg_ready_o are high.
// Write configuration only while no transaction is in flight.
// Throughput: one pixel per cycle while busy_o is low. Path: each pixel goes
// through the two-entry queue, then the 17-stage square root and the
// 8-stage divider.
// Reset: configuration registers clear to zero, the queue empties and all
// in-flight transactions are dropped.
// ----------------------------------------------------------------------------
module radial_brush_alpha_mask_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbam_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rbam_pkg::RegW-1:0]       cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [rbam_pkg::CoordW-1:0]     pixel_x_i,
  input  logic [rbam_pkg::CoordW-1:0]     pixel_y_i,
  output logic                            alpha_valid_o,
  output logic [rbam_pkg::AlphaW-1:0]     alpha_o
);

  rbam_pkg::push_t push;
  rbam_pkg::item_t head;
  logic full, empty;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = full;

  rbam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .full_i      (full),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .push_o      (push)
  );

  rbam_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (1'b1),
    .full_o  (full),
    .empty_o (empty),
    .item_o  (head)
  );

  rbam_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!empty),
    .item_i        (head),
    .alpha_valid_o (alpha_valid_o),
    .alpha_o       (alpha_o)
  );

endmodule
